// ----- sv/bfra_pkg.sv -----
// Package for the best-fit range allocator: codes, defaults, table control struct.
// Used by bfra_table and best_fit_range_allocator; depends on nothing else.
package bfra_pkg;

   // Fixed widths of the beat fields
   localparam int FIELD_W  = 40;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int AGE_W    = 32;

   // Parameter defaults
   localparam int MAX_RANGES_DEF   = 64;
   localparam int GRANULE_BITS_DEF = 6;
   localparam int MIN_POOL_DEF     = 64;
   localparam int ADDR_BITS_DEF    = 40;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INIT  = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FRAG     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOMEM    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TOOSMALL = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_ALLOC_DONE,
      S_FPREV_SCAN,
      S_FPREV_DONE,
      S_FNEXT_SCAN,
      S_FNEXT_DONE,
      S_RESP
   } state_type;

   // Control of the range table for one cycle
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_en;
      logic clr_all;
   } tab_ctl_type;

endpackage

// ----- sv/bfra_table.sv -----
// Range table: start/length/age memory with a registered read port, per-entry
// valid flags and a lowest-free-slot finder. Depends on bfra_pkg.
module bfra_table #(
   parameter int MAX_RANGES = bfra_pkg::MAX_RANGES_DEF,
   parameter int ADDR_BITS  = bfra_pkg::ADDR_BITS_DEF,
   parameter int IDX_W      = $clog2(MAX_RANGES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bfra_pkg::tab_ctl_type     ctl,
   input  logic [IDX_W-1:0]          rd_addr,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [IDX_W-1:0]          clr_addr,
   input  logic [ADDR_BITS-1:0]      wr_start,
   input  logic [ADDR_BITS-1:0]      wr_len,
   input  logic [bfra_pkg::AGE_W-1:0] wr_age,
   output logic [ADDR_BITS-1:0]      rd_start,
   output logic [ADDR_BITS-1:0]      rd_len,
   output logic [bfra_pkg::AGE_W-1:0] rd_age,
   output logic                      rd_live,
   output logic                      free_found,
   output logic [IDX_W-1:0]          free_slot
);
   import bfra_pkg::*;

   logic [ADDR_BITS-1:0] start_mem [MAX_RANGES];
   logic [ADDR_BITS-1:0] len_mem   [MAX_RANGES];
   logic [AGE_W-1:0]     age_mem   [MAX_RANGES];
   logic [MAX_RANGES-1:0] live_ff;
   logic [MAX_RANGES-1:0] live_in;

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         start_mem[wr_addr] <= wr_start;
         len_mem[wr_addr]   <= wr_len;
         age_mem[wr_addr]   <= wr_age;
      end
      if (ctl.rd_en) begin
         rd_start <= start_mem[rd_addr];
         rd_len   <= len_mem[rd_addr];
         rd_age   <= age_mem[rd_addr];
         rd_live  <= live_ff[rd_addr];
      end
   end

   // Valid flags: clear all, clear one, then a write marks its entry live
   always_comb begin
      live_in = live_ff;
      if (ctl.clr_all) live_in = '0;
      if (ctl.clr_en)  live_in[clr_addr] = 1'b0;
      if (ctl.wr_en)   live_in[wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   // Lowest empty slot
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = MAX_RANGES - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_found = 1'b1;
            free_slot  = IDX_W'(i);
         end
      end
   end

endmodule

// ----- sv/best_fit_range_allocator.sv -----
// Best-fit free-range allocator over a table of MAX_RANGES ranges held in one
// memory with separate read and write ports, read one entry per cycle. Allocation
// takes one table pass. Free takes one pass to find the range below and the
// nearest range at or above the offset, then one more pass per following range
// merged plus a final one. Reinitialise, zero size and other early answers skip
// the table pass. A new request is taken while a response still waits.
// Depends on bfra_pkg and bfra_table.
module best_fit_range_allocator #(
   parameter int MAX_RANGES   = bfra_pkg::MAX_RANGES_DEF,
   parameter int GRANULE_BITS = bfra_pkg::GRANULE_BITS_DEF,
   parameter int MIN_POOL     = bfra_pkg::MIN_POOL_DEF,
   parameter int ADDR_BITS    = bfra_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bfra_pkg::MODE_W-1:0]   req_mode,
   input  logic [bfra_pkg::FIELD_W-1:0]  req_offset,
   input  logic [bfra_pkg::FIELD_W-1:0]  req_bytes,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bfra_pkg::STATUS_W-1:0] rsp_status,
   output logic [bfra_pkg::FIELD_W-1:0]  rsp_granted_offset,
   output logic [bfra_pkg::FIELD_W-1:0]  rsp_granted_size,
   output logic [bfra_pkg::FIELD_W-1:0]  rsp_free_total
);
   import bfra_pkg::*;

   localparam int AW    = ADDR_BITS;
   localparam int IDX_W = $clog2(MAX_RANGES);
   localparam int NL_W  = AW + IDX_W + 2;
   localparam logic [AW-1:0] AMASK = {AW{1'b1}};
   localparam logic [AW:0]   GMASK = (AW+1)'((64'd1 << GRANULE_BITS) - 64'd1);
   localparam logic [AW-1:0] MINP  = AW'(MIN_POOL);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);

   // Control state
   state_type state_ff, state_in;
   logic issuing_ff, issuing_in;
   logic [IDX_W-1:0] issue_idx_ff, issue_idx_in;
   logic rdv_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AGE_W-1:0] age_ctr_ff, age_ctr_in;
   logic [AW-1:0] free_bytes_ff, free_bytes_in;
   logic [AW-1:0] alloc_bytes_ff, alloc_bytes_in;
   logic [AW-1:0] obj_cnt_ff, obj_cnt_in;

   // Payload
   logic [AW-1:0] off_ff, off_in, sz_ff, sz_in, need_ff, need_in;
   logic best_found_ff, best_found_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [AW-1:0] best_start_ff, best_start_in, best_len_ff, best_len_in;
   logic [AGE_W-1:0] best_dage_ff, best_dage_in;
   logic prev_found_ff, prev_found_in;
   logic [IDX_W-1:0] prev_idx_ff, prev_idx_in;
   logic [AW-1:0] prev_start_ff, prev_start_in, prev_len_ff, prev_len_in;
   logic [AW-1:0] ns_ff, ns_in;
   logic [NL_W-1:0] nl_ff, nl_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [AW-1:0] res_goff_ff, res_goff_in, res_gsize_ff, res_gsize_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FIELD_W-1:0] rsp_goff_ff, rsp_goff_in, rsp_gsize_ff, rsp_gsize_in;
   logic [FIELD_W-1:0] rsp_free_ff, rsp_free_in;

   // Table interface
   tab_ctl_type tab_ctl;
   logic [IDX_W-1:0] wr_addr, clr_addr;
   logic [AW-1:0] wr_start, wr_len;
   logic [AGE_W-1:0] wr_age;
   logic [AW-1:0] rd_start, rd_len;
   logic [AGE_W-1:0] rd_age;
   logic rd_live, free_found;
   logic [IDX_W-1:0] free_slot;

   // Scratch
   logic [AW-1:0] in_off, in_sz;
   logic [AW:0] need_sum, need_rnd, sum_a;
   logic [AGE_W-1:0] dage;
   logic last_beat, pmerge, nmerge;
   logic [NL_W-1:0] run_end;

   bfra_table #(
      .MAX_RANGES (MAX_RANGES),
      .ADDR_BITS  (AW),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tab_ctl),
      .rd_addr    (issue_idx_ff),
      .wr_addr    (wr_addr),
      .clr_addr   (clr_addr),
      .wr_start   (wr_start),
      .wr_len     (wr_len),
      .wr_age     (wr_age),
      .rd_start   (rd_start),
      .rd_len     (rd_len),
      .rd_age     (rd_age),
      .rd_live    (rd_live),
      .free_found (free_found),
      .free_slot  (free_slot)
   );

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_granted_offset = rsp_goff_ff;
   assign rsp_granted_size   = rsp_gsize_ff;
   assign rsp_free_total     = rsp_free_ff;

   assign in_off    = req_offset[AW-1:0];
   assign in_sz     = req_bytes[AW-1:0];
   assign need_sum  = {1'b0, in_sz} + GMASK;
   assign need_rnd  = need_sum & ~GMASK;
   assign dage      = age_ctr_ff - rd_age;
   assign last_beat = rdv_ff && (rd_idx_ff == LAST_IDX);
   assign run_end   = NL_W'(ns_ff) + nl_ff;
   assign sum_a     = {1'b0, prev_start_ff} + {1'b0, prev_len_ff};
   assign pmerge    = prev_found_ff && (sum_a == {1'b0, off_ff});
   assign nmerge    = best_found_ff &&
                      ({1'b0, best_start_ff} == ({1'b0, off_ff} + {1'b0, sz_ff}));

   // Next state and datapath
   always_comb begin
      state_in       = state_ff;
      issuing_in     = issuing_ff;
      issue_idx_in   = issue_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      age_ctr_in     = age_ctr_ff;
      free_bytes_in  = free_bytes_ff;
      alloc_bytes_in = alloc_bytes_ff;
      obj_cnt_in     = obj_cnt_ff;
      off_in         = off_ff;
      sz_in          = sz_ff;
      need_in        = need_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_start_in  = best_start_ff;
      best_len_in    = best_len_ff;
      best_dage_in   = best_dage_ff;
      prev_found_in  = prev_found_ff;
      prev_idx_in    = prev_idx_ff;
      prev_start_in  = prev_start_ff;
      prev_len_in    = prev_len_ff;
      ns_in          = ns_ff;
      nl_in          = nl_ff;
      res_status_in  = res_status_ff;
      res_goff_in    = res_goff_ff;
      res_gsize_in   = res_gsize_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_goff_in    = rsp_goff_ff;
      rsp_gsize_in   = rsp_gsize_ff;
      rsp_free_in    = rsp_free_ff;
      tab_ctl        = '0;
      wr_addr        = '0;
      clr_addr       = '0;
      wr_start       = '0;
      wr_len         = '0;
      wr_age         = age_ctr_ff;

      // Table pass: issue one read per cycle
      if (issuing_ff) begin
         tab_ctl.rd_en = 1'b1;
         if (issue_idx_ff == LAST_IDX) begin
            issuing_in = 1'b0;
         end else begin
            issue_idx_in = issue_idx_ff + 1'b1;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               off_in        = in_off;
               sz_in         = in_sz;
               need_in       = need_rnd[AW-1:0];
               res_status_in = ST_OK;
               res_goff_in   = '0;
               res_gsize_in  = '0;
               best_found_in = 1'b0;
               prev_found_in = 1'b0;
               issue_idx_in  = '0;
               state_in      = S_RESP;
               case (req_mode)
                  MODE_INIT: begin
                     if (in_sz < MINP) begin
                        res_status_in = ST_TOOSMALL;
                     end else begin
                        tab_ctl.clr_all = 1'b1;
                        tab_ctl.wr_en   = 1'b1;
                        wr_addr         = '0;
                        wr_start        = '0;
                        wr_len          = in_sz;
                        wr_age          = '0;
                        age_ctr_in      = AGE_W'(1);
                        free_bytes_in   = in_sz;
                        alloc_bytes_in  = '0;
                        obj_cnt_in      = '0;
                     end
                  end
                  MODE_ALLOC: begin
                     if (in_sz == '0) begin
                        res_status_in = ST_ZERO;
                     end else if (need_rnd[AW]) begin
                        res_status_in = ST_NOMEM;
                     end else begin
                        issuing_in = 1'b1;
                        state_in   = S_ALLOC_SCAN;
                     end
                  end
                  MODE_FREE: begin
                     if (in_sz == '0) begin
                        res_status_in = ST_ZERO;
                     end else begin
                        issuing_in = 1'b1;
                        state_in   = S_FPREV_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // Smallest fitting live range, oldest among equal lengths
         S_ALLOC_SCAN: begin
            if (rdv_ff && rd_live && rd_len >= need_ff) begin
               if (!best_found_ff || rd_len < best_len_ff ||
                   (rd_len == best_len_ff && dage > best_dage_ff)) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_start_in = rd_start;
                  best_len_in   = rd_len;
                  best_dage_in  = dage;
               end
            end
            if (last_beat) state_in = S_ALLOC_DONE;
         end

         S_ALLOC_DONE: begin
            state_in = S_RESP;
            if (!best_found_ff) begin
               res_status_in = (free_bytes_ff >= need_ff) ? ST_FRAG : ST_NOMEM;
            end else begin
               if (best_len_ff > need_ff) begin
                  tab_ctl.wr_en = 1'b1;
                  wr_addr       = best_idx_ff;
                  wr_start      = best_start_ff + need_ff;
                  wr_len        = best_len_ff - need_ff;
                  age_ctr_in    = age_ctr_ff + 1'b1;
               end else begin
                  tab_ctl.clr_en = 1'b1;
                  clr_addr       = best_idx_ff;
               end
               res_goff_in    = best_start_ff;
               res_gsize_in   = need_ff;
               sum_sat_alloc: begin
                  logic [AW:0] s;
                  s = {1'b0, alloc_bytes_ff} + {1'b0, need_ff};
                  alloc_bytes_in = s[AW] ? AMASK : s[AW-1:0];
               end
               free_bytes_in  = (free_bytes_ff >= need_ff) ? free_bytes_ff - need_ff : '0;
               obj_cnt_in     = (obj_cnt_ff == AMASK) ? obj_cnt_ff : obj_cnt_ff + 1'b1;
            end
         end

         // Nearest live range below the offset and lowest at or above it
         S_FPREV_SCAN: begin
            if (rdv_ff && rd_live) begin
               if (rd_start < off_ff) begin
                  if (!prev_found_ff || rd_start > prev_start_ff) begin
                     prev_found_in = 1'b1;
                     prev_idx_in   = rd_idx_ff;
                     prev_start_in = rd_start;
                     prev_len_in   = rd_len;
                  end
               end else if (!best_found_ff || rd_start < best_start_ff) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_start_in = rd_start;
                  best_len_in   = rd_len;
               end
            end
            if (last_beat) state_in = S_FPREV_DONE;
         end

         S_FPREV_DONE: begin
            if (!free_found && !pmerge && !nmerge) begin
               res_status_in = ST_FULL;
               state_in      = S_RESP;
            end else begin
               if (pmerge) begin
                  ns_in          = prev_start_ff;
                  nl_in          = NL_W'(sz_ff) + NL_W'(prev_len_ff);
                  tab_ctl.clr_en = 1'b1;
                  clr_addr       = prev_idx_ff;
               end else begin
                  ns_in = off_ff;
                  nl_in = NL_W'(sz_ff);
               end
               best_found_in = 1'b0;
               issue_idx_in  = '0;
               issuing_in    = 1'b1;
               state_in      = S_FNEXT_SCAN;
            end
         end

         // Lowest live range at or above the offset
         S_FNEXT_SCAN: begin
            if (rdv_ff && rd_live && rd_start >= off_ff) begin
               if (!best_found_ff || rd_start < best_start_ff) begin
                  best_found_in = 1'b1;
                  best_idx_in   = rd_idx_ff;
                  best_start_in = rd_start;
                  best_len_in   = rd_len;
               end
            end
            if (last_beat) state_in = S_FNEXT_DONE;
         end

         S_FNEXT_DONE: begin
            if (best_found_ff && NL_W'(best_start_ff) == run_end) begin
               // absorb it and look again
               nl_in          = nl_ff + NL_W'(best_len_ff);
               tab_ctl.clr_en = 1'b1;
               clr_addr       = best_idx_ff;
               best_found_in  = 1'b0;
               issue_idx_in   = '0;
               issuing_in     = 1'b1;
               state_in       = S_FNEXT_SCAN;
            end else begin
               tab_ctl.wr_en  = 1'b1;
               wr_addr        = free_found ? free_slot : LAST_IDX;
               wr_start       = ns_ff;
               wr_len         = (nl_ff > NL_W'(AMASK)) ? AMASK : nl_ff[AW-1:0];
               age_ctr_in     = age_ctr_ff + 1'b1;
               alloc_bytes_in = (alloc_bytes_ff >= sz_ff) ? alloc_bytes_ff - sz_ff : '0;
               sum_sat_free: begin
                  logic [AW:0] s;
                  s = {1'b0, free_bytes_ff} + {1'b0, sz_ff};
                  free_bytes_in = s[AW] ? AMASK : s[AW-1:0];
               end
               obj_cnt_in     = (obj_cnt_ff != '0) ? obj_cnt_ff - 1'b1 : obj_cnt_ff;
               state_in       = S_RESP;
            end
         end

         // Hand the result to the output register once it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_goff_in   = FIELD_W'(res_goff_ff);
               rsp_gsize_in  = FIELD_W'(res_gsize_ff);
               rsp_free_in   = FIELD_W'(free_bytes_ff);
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         issuing_ff     <= 1'b0;
         rdv_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         age_ctr_ff     <= '0;
         free_bytes_ff  <= '0;
         alloc_bytes_ff <= '0;
         obj_cnt_ff     <= '0;
      end else begin
         state_ff       <= state_in;
         issuing_ff     <= issuing_in;
         rdv_ff         <= tab_ctl.rd_en;
         rsp_valid_ff   <= rsp_valid_in;
         age_ctr_ff     <= age_ctr_in;
         free_bytes_ff  <= free_bytes_in;
         alloc_bytes_ff <= alloc_bytes_in;
         obj_cnt_ff     <= obj_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      issue_idx_ff  <= issue_idx_in;
      rd_idx_ff     <= issue_idx_ff;
      off_ff        <= off_in;
      sz_ff         <= sz_in;
      need_ff       <= need_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      best_dage_ff  <= best_dage_in;
      prev_found_ff <= prev_found_in;
      prev_idx_ff   <= prev_idx_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff   <= prev_len_in;
      ns_ff         <= ns_in;
      nl_ff         <= nl_in;
      res_status_ff <= res_status_in;
      res_goff_ff   <= res_goff_in;
      res_gsize_ff  <= res_gsize_in;
      rsp_status_ff <= rsp_status_in;
      rsp_goff_ff   <= rsp_goff_in;
      rsp_gsize_ff  <= rsp_gsize_in;
      rsp_free_ff   <= rsp_free_in;
   end

   // Checks
   a_best_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALLOC_DONE && best_found_ff) |-> (best_len_ff >= need_ff))
      else $error("chosen range shorter than request");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_gsize_ff == '0))
      else $error("failed response carries a grant");

   a_beat_in_scan: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> (state_ff == S_ALLOC_SCAN || state_ff == S_FPREV_SCAN ||
                  state_ff == S_FNEXT_SCAN))
      else $error("table read beat outside a pass");

   a_clear_idle: assert property (@(posedge clock) disable iff (reset)
      tab_ctl.clr_all |-> (state_ff == S_IDLE && req_valid))
      else $error("table cleared outside reinitialise");

endmodule

// ----- bench/bfra_checker.sv -----
`timescale 1ns / 100ps
// Checker for the best-fit range allocator: watches both channels, predicts each
// response from its own copy of the range table and compares. Depends on bfra_pkg.
module bfra_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [bfra_pkg::MODE_W-1:0]   req_mode,
   input  logic [bfra_pkg::FIELD_W-1:0]  req_offset,
   input  logic [bfra_pkg::FIELD_W-1:0]  req_bytes,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [bfra_pkg::STATUS_W-1:0] rsp_status,
   input  logic [bfra_pkg::FIELD_W-1:0]  rsp_granted_offset,
   input  logic [bfra_pkg::FIELD_W-1:0]  rsp_granted_size,
   input  logic [bfra_pkg::FIELD_W-1:0]  rsp_free_total,
   output int                            errors,
   output int                            pending
);
   import bfra_pkg::*;

   localparam int          NR    = MAX_RANGES_DEF;
   localparam int          GBITS = GRANULE_BITS_DEF;
   localparam longint      AMAX  = (64'd1 << ADDR_BITS_DEF) - 1;
   localparam longint      GMSK  = (64'd1 << GBITS) - 1;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [FIELD_W-1:0]  goff;
      logic [FIELD_W-1:0]  gsize;
      logic [FIELD_W-1:0]  ftotal;
   } grant_type;

   grant_type grants_due[$];

   // predicted pool state
   logic [63:0]      rng_start [NR];
   logic [63:0]      rng_len   [NR];
   bit               rng_vld   [NR];
   logic [AGE_W-1:0] rng_age   [NR];
   logic [AGE_W-1:0] age_cnt;
   logic [63:0]      free_b, alloc_b, objects;

   function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > AMAX) ? AMAX : s;
   endfunction

   function automatic void store_range(int slot, logic [63:0] st, logic [63:0] ln);
      rng_start[slot] = st & AMAX;
      rng_len[slot]   = (ln > AMAX) ? AMAX : ln;
      rng_vld[slot]   = 1'b1;
      rng_age[slot]   = age_cnt;
      age_cnt++;
   endfunction

   function automatic int lowest_from(logic [63:0] lo);
      int b;
      b = -1;
      for (int i = 0; i < NR; i++)
         if (rng_vld[i] && rng_start[i] >= lo && (b < 0 || rng_start[i] < rng_start[b]))
            b = i;
      return b;
   endfunction

   function automatic void clear_pool();
      foreach (rng_vld[i]) rng_vld[i] = 1'b0;
      age_cnt = '0;
      free_b  = '0;
      alloc_b = '0;
      objects = '0;
   endfunction

   // work out the response of one request and update the pool copy
   function automatic grant_type allocate_step(logic [MODE_W-1:0] md, logic [63:0] off,
                                               logic [63:0] sz);
      grant_type g;
      logic [63:0] need, s, l, ns, nl;
      int best, prv, empty, nx, n, slot;
      bit pm, nm;
      g.status = ST_OK;
      g.goff   = '0;
      g.gsize  = '0;
      if (md == MODE_INIT) begin
         if (sz < MIN_POOL_DEF) g.status = ST_TOOSMALL;
         else begin
            clear_pool();
            store_range(0, 0, sz);
            free_b = sz;
         end
      end else if (md == MODE_ALLOC) begin
         if (sz == 0) g.status = ST_ZERO;
         else begin
            need = (sz + GMSK) & ~GMSK;
            if (need > AMAX) g.status = ST_NOMEM;
            else begin
               best = -1;
               for (int i = 0; i < NR; i++) begin
                  if (!rng_vld[i] || rng_len[i] < need) continue;
                  if (best < 0 || rng_len[i] < rng_len[best] ||
                      (rng_len[i] == rng_len[best] &&
                       AGE_W'(age_cnt - rng_age[i]) > AGE_W'(age_cnt - rng_age[best])))
                     best = i;
               end
               if (best < 0) g.status = (free_b >= need) ? ST_FRAG : ST_NOMEM;
               else begin
                  s = rng_start[best];
                  l = rng_len[best];
                  rng_vld[best] = 1'b0;
                  if (l > need) store_range(best, s + need, l - need);
                  g.goff  = s[FIELD_W-1:0];
                  g.gsize = need[FIELD_W-1:0];
                  alloc_b = sat_sum(alloc_b, need);
                  free_b  = free_b - ((need < free_b) ? need : free_b);
                  objects = sat_sum(objects, 1);
               end
            end
         end
      end else if (md == MODE_FREE) begin
         if (sz == 0) g.status = ST_ZERO;
         else begin
            prv   = -1;
            empty = -1;
            for (int i = 0; i < NR; i++) begin
               if (!rng_vld[i]) begin
                  if (empty < 0) empty = i;
                  continue;
               end
               if (rng_start[i] < off && (prv < 0 || rng_start[i] > rng_start[prv]))
                  prv = i;
            end
            pm = (prv >= 0) && (rng_start[prv] + rng_len[prv] == off);
            nx = lowest_from(off);
            nm = (nx >= 0) && (rng_start[nx] == off + sz);
            if (empty < 0 && !pm && !nm) g.status = ST_FULL;
            else begin
               ns = off;
               nl = sz;
               if (pm) begin
                  ns = rng_start[prv];
                  nl += rng_len[prv];
                  rng_vld[prv] = 1'b0;
               end
               // absorb every range that starts at the running end
               forever begin
                  n = lowest_from(off);
                  if (n < 0 || rng_start[n] != ns + nl) break;
                  nl += rng_len[n];
                  rng_vld[n] = 1'b0;
               end
               slot = 0;
               while (slot < NR - 1 && rng_vld[slot]) slot++;
               store_range(slot, ns, nl);
               alloc_b = alloc_b - ((sz < alloc_b) ? sz : alloc_b);
               free_b  = sat_sum(free_b, sz);
               if (objects > 0) objects--;
            end
         end
      end
      g.ftotal = free_b[FIELD_W-1:0];
      return g;
   endfunction

   assign pending = grants_due.size();

   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         clear_pool();
         grants_due.delete();
         errors <= 0;
      end else begin
         // response beat against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (grants_due.size() == 0) begin
               $display("%0t: response beat with nothing expected (status %0d)",
                        $time, rsp_status);
               errors <= errors + 1;
            end else begin
               want = grants_due.pop_front();
               if (rsp_status !== want.status || rsp_granted_offset !== want.goff ||
                   rsp_granted_size !== want.gsize || rsp_free_total !== want.ftotal) begin
                  $display("%0t: mismatch exp st=%0d off=%h sz=%h free=%h",
                           $time, want.status, want.goff, want.gsize, want.ftotal);
                  $display("%0t:          act st=%0d off=%h sz=%h free=%h",
                           $time, rsp_status, rsp_granted_offset, rsp_granted_size,
                           rsp_free_total);
                  errors <= errors + 1;
               end
            end
         end
         // request beat
         if (req_valid && req_ready)
            grants_due.insert(grants_due.size(),
                              allocate_step(req_mode, 64'(req_offset), 64'(req_bytes)));
      end
   end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Top of the allocator bench: clock, reset, request stimulus and the verdict.
// Depends on bfra_pkg, best_fit_range_allocator and bfra_checker.
module tb;
   import bfra_pkg::*;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode = MODE_ALLOC;
   logic [FIELD_W-1:0]  req_offset = '0;
   logic [FIELD_W-1:0]  req_bytes = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [FIELD_W-1:0]  rsp_granted_offset, rsp_granted_size, rsp_free_total;
   int                  errors, pending;
   int                  send_idle = 0, recv_stall = 0;
   int                  beats_sent = 0;

   localparam logic [FIELD_W-1:0] FMAX = {FIELD_W{1'b1}};
   // mode code the block does not define
   localparam logic [MODE_W-1:0]  MODE_SPARE = 2'd3;

   typedef struct { logic [FIELD_W-1:0] off, len; } block_type;
   block_type live_blocks[$];

   always #4 clock = ~clock;

   best_fit_range_allocator u_top (.*);

   bfra_checker u_chk (.*);

   // receiver back-pressure
   always @(negedge clock)
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall);

   // remember granted blocks so they can be handed back later
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready && rsp_granted_size != 0)
         live_blocks.insert(live_blocks.size(), '{rsp_granted_offset, rsp_granted_size});

   // drive one request beat; valid is held until taken
   task automatic send(logic [MODE_W-1:0] md, logic [FIELD_W-1:0] off,
                       logic [FIELD_W-1:0] sz);
      @(negedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid  <= 1'b1;
      req_mode   <= md;
      req_offset <= off;
      req_bytes  <= sz;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      if (md == MODE_INIT) live_blocks.delete();
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [FIELD_W-1:0] rand_field();
      return FIELD_W'({$urandom, $urandom});
   endfunction

   function automatic logic [FIELD_W-1:0] small_size();
      return ($urandom_range(9) == 0) ? FIELD_W'($urandom_range(1, 1 << 16))
                                      : FIELD_W'($urandom_range(1, 512));
   endfunction

   // one random request or a run of frees, mostly well-formed pool traffic
   task automatic random_beat();
      int pick, k;
      logic [FIELD_W-1:0] base;
      pick = $urandom_range(99);
      if (pick < 3) begin
         case ($urandom_range(3))
            0: send(MODE_INIT, rand_field(), FIELD_W'($urandom_range(0, 63)));
            1: send(MODE_INIT, rand_field(), rand_field());
            default: send(MODE_INIT, rand_field(), FIELD_W'($urandom_range(64, 1 << 16)));
         endcase
      end else if (pick < 48) begin
         send(MODE_ALLOC, rand_field(), ($urandom_range(29) == 0) ? rand_field()
                                                                 : small_size());
      end else if (pick < 86 && live_blocks.size() != 0) begin
         k = $urandom_range(live_blocks.size() - 1);
         send(MODE_FREE, live_blocks[k].off, live_blocks[k].len);
         live_blocks.delete(k);
      end else if (pick < 91) begin
         send(MODE_FREE, rand_field(), ($urandom_range(1)) ? rand_field() : small_size());
      end else if (pick < 92) begin
         // seventy isolated frees far above the pool, more than the table holds
         base = {8'($urandom_range(1, 255)), 32'h0};
         for (int i = 0; i < 70; i++)
            send(MODE_FREE, base + FIELD_W'(i * 256), 64);
      end else begin
         case ($urandom_range(2))
            0: send(MODE_ALLOC, rand_field(), '0);
            1: send(MODE_FREE, rand_field(), '0);
            default: send(MODE_SPARE, rand_field(), rand_field());
         endcase
      end
   endtask

   initial begin
      #30ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pool edges, rounding, zero size, unknown mode
      send(MODE_ALLOC, 0, 64);
      send(MODE_INIT, 0, 63);
      send(MODE_INIT, 0, FMAX);
      send(MODE_ALLOC, 0, FMAX);
      send(MODE_ALLOC, 0, FMAX - 63);
      send(MODE_INIT, FMAX, 64);
      send(MODE_ALLOC, 0, 0);
      send(MODE_FREE, 0, 0);
      send(MODE_SPARE, FMAX, FMAX);
      send(MODE_ALLOC, 0, 1);
      send(MODE_ALLOC, 0, 1);
      send(MODE_INIT, 0, 1024);
      send(MODE_ALLOC, 0, 64);
      send(MODE_ALLOC, 0, 65);
      send(MODE_ALLOC, 0, 64);
      send(MODE_FREE, 0, 64);
      send(MODE_FREE, 192, 64);
      send(MODE_ALLOC, 0, 900);
      send(MODE_ALLOC, 0, 2000);
      send(MODE_FREE, 64, 128);
      send(MODE_ALLOC, 0, 1024);
      send(MODE_FREE, FMAX, FMAX);
      drain();

      // random phases with different idle mixes
      for (int ph = 0; beats_sent < 1500; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         if (ph == 0) send(MODE_INIT, 0, 1 << 14);
         repeat (100) random_beat();
         drain();
      end

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
sv/bfra_pkg.sv
sv/bfra_table.sv
sv/best_fit_range_allocator.sv
bench/bfra_checker.sv
bench/tb.sv
